### rtl/token_bucket_packet_guard_defines.svh
// assertion macros used by the packet guard core
`ifndef TOKEN_BUCKET_PACKET_GUARD_DEFINES_SVH
`define TOKEN_BUCKET_PACKET_GUARD_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TBPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TBPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tbpg_pkg.sv
// types and constants of the packet guard
package tbpg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUARANTINE_TICKS = 3'd4;

  // register reset values
  localparam logic [15:0] RST_BUCKET_CAPACITY  = 16'd64;
  localparam logic [15:0] RST_REFILL_RATE      = 16'd32;
  localparam logic [7:0]  RST_FAILURE_LIMIT    = 8'd8;
  localparam logic [31:0] RST_GAP_LIMIT        = 32'd1024;
  localparam logic [31:0] RST_QUARANTINE_TICKS = 32'd0;

  // command codes
  localparam logic [2:0] CMD_PACKET  = 3'd0;
  localparam logic [2:0] CMD_SUCCESS = 3'd1;
  localparam logic [2:0] CMD_FAILURE = 3'd2;
  localparam logic [2:0] CMD_GAP     = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;

  // verdict codes
  localparam logic [1:0] V_ACCEPT     = 2'd0;
  localparam logic [1:0] V_THROTTLE   = 2'd1;
  localparam logic [1:0] V_QUARANTINE = 2'd2;
  localparam logic [1:0] V_ANOMALY    = 2'd3;

  localparam logic [7:0] RUN_MAX = 8'hff;

  typedef struct packed {
    logic [15:0] bucket_capacity;
    logic [15:0] refill_rate;
    logic [7:0]  failure_limit;
    logic [31:0] gap_limit;
    logic [31:0] quarantine_ticks;
  } cfg_t;

  // request after the capture stage, with refill and gap test worked out
  typedef struct packed {
    logic [2:0]  command;
    logic        gap_over;
    logic [63:0] tick_number;
    logic [23:0] refill;
  } item_t;

endpackage

### rtl/tbpg_if.sv
// request and result channels of the packet guard
interface tbpg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] gap_size;
  logic [63:0] tick_number;
  logic [23:0] elapsed_q16;

  modport source (output valid, command, gap_size, tick_number, elapsed_q16,
                  input ready);
  modport sink (input valid, command, gap_size, tick_number, elapsed_q16,
                output ready);
endinterface

interface tbpg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [15:0] tokens_left;
  logic        in_quarantine;
  logic [31:0] anomaly_total;

  modport source (output valid, verdict, tokens_left, in_quarantine, anomaly_total,
                  input ready);
  modport sink (input valid, verdict, tokens_left, in_quarantine, anomaly_total,
                output ready);
endinterface

### rtl/tbpg_regs.sv
// configuration register file
module tbpg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tbpg_pkg::cfg_t                 cfg,
  output logic                           cap_load
);

  tbpg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bucket_capacity  <= tbpg_pkg::RST_BUCKET_CAPACITY;
      cfg_r.refill_rate      <= tbpg_pkg::RST_REFILL_RATE;
      cfg_r.failure_limit    <= tbpg_pkg::RST_FAILURE_LIMIT;
      cfg_r.gap_limit        <= tbpg_pkg::RST_GAP_LIMIT;
      cfg_r.quarantine_ticks <= tbpg_pkg::RST_QUARANTINE_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        tbpg_pkg::REG_BUCKET_CAPACITY:  cfg_r.bucket_capacity  <= cfg_wdata[15:0];
        tbpg_pkg::REG_REFILL_RATE:      cfg_r.refill_rate      <= cfg_wdata[15:0];
        tbpg_pkg::REG_FAILURE_LIMIT:    cfg_r.failure_limit    <= cfg_wdata[7:0];
        tbpg_pkg::REG_GAP_LIMIT:        cfg_r.gap_limit        <= cfg_wdata;
        tbpg_pkg::REG_QUARANTINE_TICKS: cfg_r.quarantine_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg      = cfg_r;
  // capacity write also reloads the bucket
  assign cap_load = cfg_we && (cfg_index == tbpg_pkg::REG_BUCKET_CAPACITY);

endmodule

### rtl/tbpg_capture.sv
// input register: takes a request, works out refill and gap test
module tbpg_capture (
  input  logic           clk,
  input  logic           rst_n,
  tbpg_in_if.sink        in_ch,
  input  tbpg_pkg::cfg_t cfg,
  input  logic           advance,
  output logic           s1_valid,
  output tbpg_pkg::item_t s1_item
);

  logic            valid_r;
  tbpg_pkg::item_t item_r;
  tbpg_pkg::item_t item_nxt;
  logic [39:0]     product;
  logic            take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  // tokens per second times Q8.16 seconds, fraction dropped
  assign product = 40'(cfg.refill_rate) * 40'(in_ch.elapsed_q16);

  always_comb begin
    item_nxt.command     = in_ch.command;
    item_nxt.gap_over    = in_ch.gap_size > cfg.gap_limit;
    item_nxt.tick_number = in_ch.tick_number;
    item_nxt.refill      = product[39:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

### rtl/tbpg_core.sv
// guard state update and result register
`include "token_bucket_packet_guard_defines.svh"

module tbpg_core (
  input  logic            clk,
  input  logic            rst_n,
  input  tbpg_pkg::cfg_t  cfg,
  input  logic            cap_load,
  input  logic [15:0]     cap_wdata,
  input  logic            s1_valid,
  input  tbpg_pkg::item_t s1_item,
  output logic            advance,
  tbpg_out_if.source      out_ch
);

  logic [15:0] tok_r, tok_nxt;
  logic [7:0]  run_r, run_nxt;
  logic        quar_r, quar_nxt;
  logic [63:0] deadline_r, deadline_nxt;
  logic [63:0] last_tick_r, last_tick_nxt;
  logic [31:0] anom_r, anom_nxt;
  logic [1:0]  verdict;

  logic        out_valid_r;
  logic [1:0]  out_verdict_r;
  logic [15:0] out_tok_r;
  logic        out_quar_r;
  logic [31:0] out_anom_r;

  logic        fire;
  logic [7:0]  run_inc;
  logic [64:0] deadline_sum;
  logic [24:0] refill_sum;

  logic        chk_spend;
  logic        chk_anom;
  logic        chk_quar_pkt;

  assign advance = !out_valid_r || out_ch.ready;
  assign fire    = s1_valid && advance;

  assign run_inc      = (run_r == tbpg_pkg::RUN_MAX) ? run_r : run_r + 8'd1;
  assign deadline_sum = {1'b0, last_tick_r} + {33'd0, cfg.quarantine_ticks};
  assign refill_sum   = {9'd0, tok_r} + {1'b0, s1_item.refill};

  always_comb begin
    tok_nxt       = tok_r;
    run_nxt       = run_r;
    quar_nxt      = quar_r;
    deadline_nxt  = deadline_r;
    last_tick_nxt = last_tick_r;
    anom_nxt      = anom_r;
    verdict       = tbpg_pkg::V_ACCEPT;
    case (s1_item.command)
      tbpg_pkg::CMD_PACKET: begin
        if (quar_r) begin
          verdict = tbpg_pkg::V_QUARANTINE;
        end else if (tok_r != 16'd0) begin
          tok_nxt = tok_r - 16'd1;
        end else begin
          verdict = tbpg_pkg::V_THROTTLE;
        end
      end
      tbpg_pkg::CMD_SUCCESS: begin
        run_nxt = 8'd0;
      end
      tbpg_pkg::CMD_FAILURE: begin
        run_nxt = run_inc;
        if (run_inc >= cfg.failure_limit && !quar_r) begin
          quar_nxt     = 1'b1;
          deadline_nxt = deadline_sum[64] ? '1 : deadline_sum[63:0];
          verdict      = tbpg_pkg::V_QUARANTINE;
        end
      end
      tbpg_pkg::CMD_GAP: begin
        if (s1_item.gap_over) begin
          anom_nxt = anom_r + 32'd1;
          verdict  = tbpg_pkg::V_ANOMALY;
        end
      end
      tbpg_pkg::CMD_TICK: begin
        last_tick_nxt = s1_item.tick_number;
        if (s1_item.refill != 24'd0) begin
          tok_nxt = (refill_sum < {9'd0, cfg.bucket_capacity}) ? refill_sum[15:0]
                                                               : cfg.bucket_capacity;
        end
        if (quar_r && s1_item.tick_number >= deadline_r) begin
          quar_nxt = 1'b0;
          run_nxt  = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r       <= tbpg_pkg::RST_BUCKET_CAPACITY;
      run_r       <= 8'd0;
      quar_r      <= 1'b0;
      deadline_r  <= 64'd0;
      last_tick_r <= 64'd0;
      anom_r      <= 32'd0;
    end else begin
      if (fire) begin
        tok_r       <= tok_nxt;
        run_r       <= run_nxt;
        quar_r      <= quar_nxt;
        deadline_r  <= deadline_nxt;
        last_tick_r <= last_tick_nxt;
        anom_r      <= anom_nxt;
      end
      // capacity write reloads the bucket with the value being written
      if (cap_load) begin
        tok_r <= cap_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_verdict_r <= verdict;
      out_tok_r     <= tok_nxt;
      out_quar_r    <= quar_nxt;
      out_anom_r    <= anom_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.verdict       = out_verdict_r;
  assign out_ch.tokens_left   = out_tok_r;
  assign out_ch.in_quarantine = out_quar_r;
  assign out_ch.anomaly_total = out_anom_r;

  assign chk_spend    = fire && !cap_load && (s1_item.command == tbpg_pkg::CMD_PACKET) &&
                        !quar_r && (tok_r != 16'd0);
  assign chk_anom     = fire && (s1_item.command == tbpg_pkg::CMD_GAP) && s1_item.gap_over;
  assign chk_quar_pkt = fire && quar_r && (s1_item.command == tbpg_pkg::CMD_PACKET);

  `TBPG_ASSERT_NOW(a_tok_in_cap, 1'b1, tok_r <= cfg.bucket_capacity, "token level above cap")
  `TBPG_ASSERT_NEXT(a_pkt_spend, chk_spend, tok_r == $past(tok_r) - 16'd1, "no token spent")
  `TBPG_ASSERT_NEXT(a_anom_count, chk_anom, anom_r == $past(anom_r) + 32'd1, "anomaly not counted")
  `TBPG_ASSERT_NEXT(a_anom_verdict, chk_anom, out_verdict_r == tbpg_pkg::V_ANOMALY, "no alert")
  `TBPG_ASSERT_NEXT(a_quar_pkt, chk_quar_pkt, out_verdict_r == tbpg_pkg::V_QUARANTINE, "quar pass")

endmodule

### rtl/token_bucket_packet_guard.sv
// throughput: one request per cycle, held off only while a result waits on out_ch.ready
// each request passes an input register and then one update of the guard state
// reset (synchronous, rst_n low): registers to defaults, bucket full, no quarantine,
// counters and tick history zero, both pipeline stages empty
module token_bucket_packet_guard (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tbpg_in_if.sink                        in_ch,
  tbpg_out_if.source                     out_ch
);

  // register file; the user must write it only while the guard is idle, the block does not enforce this
  tbpg_pkg::cfg_t cfg;
  logic           cap_load;

  // capture stage to update stage
  logic            s1_valid;
  tbpg_pkg::item_t s1_item;
  logic            advance;

  tbpg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cap_load  (cap_load)
  );

  // input register; the refill product and the gap compare are done here so
  // the update stage only adds, clamps and compares ticks
  tbpg_capture u_capture (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // state read-modify-write and result register; the next request sees the
  // updated state in the following cycle
  tbpg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cap_load  (cap_load),
    .cap_wdata (cfg_wdata[15:0]),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .advance   (advance),
    .out_ch    (out_ch)
  );

endmodule

### sim/tbpg_verdict_checker.sv
// scoreboard of the packet guard: follows register writes, predicts each verdict and checks it
module tbpg_verdict_checker
  import tbpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tbpg_in_if                    in_ch,
  tbpg_out_if                   out_ch,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] tokens_left;
    logic        in_quarantine;
    logic [31:0] anomaly_total;
  } guard_result_t;

  cfg_t        regs;
  logic [15:0] tokens;
  logic [7:0]  fail_run;
  logic        quarantined;
  logic [63:0] deadline;
  logic [63:0] last_tick;
  logic [31:0] anomalies;

  guard_result_t pending_verdicts[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic guard_result_t police_request(input logic [2:0]  cmd,
                                                   input logic [31:0] gap,
                                                   input logic [63:0] tick,
                                                   input logic [23:0] elapsed);
    guard_result_t r;
    logic [39:0]   product;
    logic [23:0]   refill;
    logic [24:0]   sum;
    logic [64:0]   due;
    r.verdict = V_ACCEPT;
    case (cmd)
      CMD_PACKET: begin
        if (quarantined) begin
          r.verdict = V_QUARANTINE;
        end else if (tokens != 16'd0) begin
          tokens = tokens - 16'd1;
        end else begin
          r.verdict = V_THROTTLE;
        end
      end
      CMD_SUCCESS: begin
        fail_run = '0;
      end
      CMD_FAILURE: begin
        if (fail_run != RUN_MAX) begin
          fail_run = fail_run + 8'd1;
        end
        if (fail_run >= regs.failure_limit && !quarantined) begin
          quarantined = 1'b1;
          due = {1'b0, last_tick} + {33'd0, regs.quarantine_ticks};
          deadline = due[64] ? '1 : due[63:0];
          r.verdict = V_QUARANTINE;
        end
      end
      CMD_GAP: begin
        if (gap > regs.gap_limit) begin
          anomalies = anomalies + 32'd1;
          r.verdict = V_ANOMALY;
        end
      end
      CMD_TICK: begin
        product   = {24'd0, regs.refill_rate} * {16'd0, elapsed};
        refill    = product[39:16];
        last_tick = tick;
        if (refill != 24'd0) begin
          sum    = {9'd0, tokens} + {1'b0, refill};
          tokens = (sum < {9'd0, regs.bucket_capacity}) ? sum[15:0] : regs.bucket_capacity;
        end
        if (quarantined && tick >= deadline) begin
          quarantined = 1'b0;
          fail_run    = '0;
        end
      end
      default: begin
      end
    endcase
    r.tokens_left   = tokens;
    r.in_quarantine = quarantined;
    r.anomaly_total = anomalies;
    return r;
  endfunction

  always @(posedge clk) begin
    guard_result_t want;
    guard_result_t got;
    logic          bad;
    if (!rst_n) begin
      regs.bucket_capacity  = RST_BUCKET_CAPACITY;
      regs.refill_rate      = RST_REFILL_RATE;
      regs.failure_limit    = RST_FAILURE_LIMIT;
      regs.gap_limit        = RST_GAP_LIMIT;
      regs.quarantine_ticks = RST_QUARANTINE_TICKS;
      tokens      = RST_BUCKET_CAPACITY;
      fail_run    = '0;
      quarantined = 1'b0;
      deadline    = '0;
      last_tick   = '0;
      anomalies   = '0;
      pending_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BUCKET_CAPACITY: begin
            regs.bucket_capacity = cfg_wdata[15:0];
            tokens = cfg_wdata[15:0];
          end
          REG_REFILL_RATE:      regs.refill_rate      = cfg_wdata[15:0];
          REG_FAILURE_LIMIT:    regs.failure_limit    = cfg_wdata[7:0];
          REG_GAP_LIMIT:        regs.gap_limit        = cfg_wdata;
          REG_QUARANTINE_TICKS: regs.quarantine_ticks = cfg_wdata;
          default: begin
          end
        endcase
      end
      // older results leave before the new request is queued
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result with no request outstanding: verdict %0d", out_ch.verdict);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          got.verdict       = out_ch.verdict;
          got.tokens_left   = out_ch.tokens_left;
          got.in_quarantine = out_ch.in_quarantine;
          got.anomaly_total = out_ch.anomaly_total;
          bad = 1'b0;
          if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            bad = 1'b1;
          end
          if (got.tokens_left !== want.tokens_left) begin
            $error("tokens_left: expected %0d, got %0d", want.tokens_left, got.tokens_left);
            bad = 1'b1;
          end
          if (got.in_quarantine !== want.in_quarantine) begin
            $error("in_quarantine: expected %0d, got %0d",
                   want.in_quarantine, got.in_quarantine);
            bad = 1'b1;
          end
          if (got.anomaly_total !== want.anomaly_total) begin
            $error("anomaly_total: expected %0d, got %0d",
                   want.anomaly_total, got.anomaly_total);
            bad = 1'b1;
          end
          if (bad) begin
            fail_count++;
          end
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_verdicts.push_back(police_request(in_ch.command, in_ch.gap_size,
                                                  in_ch.tick_number, in_ch.elapsed_q16));
      end
    end
    pending = pending_verdicts.size();
  end

endmodule

### sim/tb_token_bucket_packet_guard.sv
// top of the packet guard testbench: clock, reset, stimulus, output back-pressure and verdict
module tb_token_bucket_packet_guard;
  import tbpg_pkg::*;

  // no request or result moving for this many cycles means the block has hung
  localparam int WATCHDOG_LIMIT  = 2000;
  // length of the one long output hold-off that fills the pipeline
  localparam int SQUEEZE_CYCLES  = 80;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 110;
  // failure storm long enough to saturate the failure run
  localparam int STORM_LENGTH    = 260;

  // command codes the block must ignore
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  // register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0] REG_RSVD_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RSVD_7 = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tbpg_in_if  in_ch ();
  tbpg_out_if out_ch ();

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  bit          squeeze_req;
  bit          sender_calm;
  bit          paused;
  logic [63:0] tick_now;
  logic [31:0] gap_lim_now;
  int          requests_sent;
  int          reg_writes;
  int          settings;
  int          phase_end;
  int          idle_cycles;

  token_bucket_packet_guard u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tbpg_verdict_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side: bursts of ready with random gaps, plus the one long squeeze on request
  initial begin : receiver
    int gap_left;
    int run_left;
    out_ch.ready = 1'b0;
    gap_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        gap_left = SQUEEZE_CYCLES;
      end
      if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          // a quarter of the bursts are long stretches with no stall at all
          run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                 : $urandom_range(0, 6);
          gap_left = pick_gap();
        end
      end
    end
  end

  // hang detector: counts cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one request, wait for the handshake, then maybe leave a gap
  // called and returns at a falling edge; valid is only lowered when a gap follows
  task automatic send_request(input logic [2:0]  cmd,
                              input logic [31:0] gap,
                              input logic [63:0] tick,
                              input logic [23:0] elapsed);
    int idle;
    in_ch.command     <= cmd;
    in_ch.gap_size    <= gap;
    in_ch.tick_number <= tick;
    in_ch.elapsed_q16 <= elapsed;
    in_ch.valid       <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
    idle = sender_calm ? 0 : pick_gap();
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
  endtask

  // stop offering and let every outstanding result come back, plus pipeline margin
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one register write per falling edge; the caller drops cfg_we after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_GAP_LIMIT) begin
      gap_lim_now = data;
    end
    reg_writes++;
    @(negedge clk);
  endtask

  // phase 0 and 1 are the two corners, the rest mix extremes with workable values
  task automatic apply_setting(input int phase);
    logic [15:0] cap;
    logic [15:0] rate;
    logic [7:0]  lim;
    logic [31:0] glim;
    logic [31:0] qtk;
    if (phase == 0) begin
      // empty bucket, fastest refill, zero failure limit, every nonzero gap flagged,
      // longest quarantine
      cap  = '0;
      rate = '1;
      lim  = '0;
      glim = '0;
      qtk  = '1;
    end else if (phase == 1) begin
      // biggest bucket, no refill, highest limit, no gap ever flagged, instant expiry
      cap  = '1;
      rate = '0;
      lim  = '1;
      glim = '1;
      qtk  = '0;
    end else begin
      case ($urandom_range(0, 5))
        0:       cap = '0;
        1:       cap = '1;
        default: cap = 16'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       rate = '0;
        1:       rate = '1;
        default: rate = 16'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 5))
        0:       lim = '0;
        1:       lim = 8'd1;
        2:       lim = '1;
        default: lim = 8'($urandom_range(2, 10));
      endcase
      case ($urandom_range(0, 5))
        0:       glim = '0;
        1:       glim = '1;
        2:       glim = $urandom;
        default: glim = $urandom_range(0, 4096);
      endcase
      case ($urandom_range(0, 5))
        0:       qtk = '0;
        1:       qtk = '1;
        2:       qtk = $urandom;
        default: qtk = $urandom_range(1, 12);
      endcase
    end
    // junk in the unused upper bits of the narrow registers must be dropped
    write_reg(REG_BUCKET_CAPACITY,  {16'($urandom), cap});
    write_reg(REG_REFILL_RATE,      {16'($urandom), rate});
    write_reg(REG_FAILURE_LIMIT,    {24'($urandom), lim});
    write_reg(REG_GAP_LIMIT,        glim);
    write_reg(REG_QUARANTINE_TICKS, qtk);
    // a write to an index with no register behind it changes nothing
    write_reg(3'($urandom_range(REG_RSVD_5, REG_RSVD_7)), $urandom);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // mostly sensible traffic: ticks that move forward, gaps around the limit,
  // occasional failure storms; the unused fields carry noise
  task automatic send_random_request();
    int          r;
    int          storm;
    logic [2:0]  cmd;
    logic [31:0] gap;
    logic [63:0] tick;
    logic [23:0] elapsed;
    r       = $urandom_range(0, 99);
    gap     = $urandom;
    tick    = {$urandom, $urandom};
    elapsed = 24'($urandom);
    if (r < 3) begin
      storm = $urandom_range(5, 40);
      repeat (storm) send_request(CMD_FAILURE, $urandom, {$urandom, $urandom}, 24'($urandom));
      return;
    end
    if (r < 35) begin
      cmd = CMD_PACKET;
    end else if (r < 45) begin
      cmd = CMD_SUCCESS;
    end else if (r < 62) begin
      cmd = CMD_FAILURE;
    end else if (r < 75) begin
      cmd = CMD_GAP;
      case ($urandom_range(0, 3))
        0:       gap = gap_lim_now;
        1:       gap = gap_lim_now + 32'd1;
        2:       gap = gap_lim_now - 32'd1;
        default: gap = $urandom;
      endcase
    end else if (r < 95) begin
      cmd = CMD_TICK;
      // now and then the tick count jumps anywhere, otherwise it creeps forward
      if ($urandom_range(0, 19) == 0) begin
        tick_now = tick;
      end else begin
        tick_now = tick_now + 64'($urandom_range(0, 4));
      end
      tick = tick_now;
      if ($urandom_range(0, 7) != 0) begin
        elapsed = 24'($urandom_range(0, 24'h030000));
      end
    end else begin
      cmd = 3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
    end
    send_request(cmd, gap, tick, elapsed);
  endtask

  initial begin : stimulus
    int phase;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_BUCKET_CAPACITY;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_PACKET;
    in_ch.gap_size    = '0;
    in_ch.tick_number = '0;
    in_ch.elapsed_q16 = '0;
    squeeze_req       = 1'b0;
    sender_calm       = 1'b0;
    paused            = 1'b0;
    tick_now          = '0;
    gap_lim_now       = RST_GAP_LIMIT;
    requests_sent     = 0;
    reg_writes        = 0;
    settings          = 1;
    idle_cycles       = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, running on the reset register values
    send_request(CMD_PACKET, '0, '0, '0);             // accepted, one token used
    send_request(CMD_GAP, RST_GAP_LIMIT, '0, '0);     // exactly at the gap limit
    send_request(CMD_GAP, RST_GAP_LIMIT + 32'd1, '0, '0);   // just over it
    send_request(CMD_GAP, '1, '0, '0);                // largest gap
    send_request(CMD_GAP, '0, '0, '0);
    send_request(CMD_TICK, '0, '1, 24'd1);            // largest tick count, refill rounds to zero
    send_request(CMD_TICK, '0, '0, '1);               // longest interval, refill capped at capacity
    send_request(CMD_SUCCESS, '0, '0, '0);
    // eight failures in a row: the last one starts a quarantine ending at tick zero
    repeat (8) send_request(CMD_FAILURE, '0, '0, '0);
    send_request(CMD_PACKET, '0, '0, '0);             // refused while quarantined
    send_request(CMD_FAILURE, '0, '0, '0);            // run grows, deadline stays put
    send_request(CMD_TICK, '0, '0, '0);               // deadline reached, quarantine over
    send_request(CMD_PACKET, '1, '1, '1);
    send_request(CMD_RSVD_5, $urandom, {$urandom, $urandom}, 24'($urandom));
    send_request(CMD_RSVD_6, $urandom, {$urandom, $urandom}, 24'($urandom));
    send_request(CMD_RSVD_7, $urandom, {$urandom, $urandom}, 24'($urandom));
    drain();

    // random phases, each under its own register setting
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_setting(phase);
      sender_calm = (phase == 4);
      if (phase == 2) begin
        // long output stall while requests keep coming
        squeeze_req = 1'b1;
      end
      phase_end = requests_sent + ITEMS_PER_PHASE;
      if (phase == 1) begin
        // limit 255: the 255th failure quarantines, later ones hold the run at its ceiling
        repeat (STORM_LENGTH) begin
          send_request(CMD_FAILURE, $urandom, {$urandom, $urandom}, 24'($urandom));
        end
      end
      while (requests_sent < phase_end) begin
        if (phase == 3 && !paused && requests_sent >= phase_end - ITEMS_PER_PHASE / 2) begin
          // sender stops until every result is back, then carries on
          drain();
          paused = 1'b1;
        end
        send_random_request();
      end
      drain();
    end

    repeat (10) @(negedge clk);
    $display("run covered %0d requests and %0d checked results", requests_sent, checked);
    $display("under %0d register settings (%0d writes), with output stalls and sender pauses",
             settings, reg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tbpg_pkg.sv
rtl/tbpg_if.sv
rtl/tbpg_regs.sv
rtl/tbpg_capture.sv
rtl/tbpg_core.sv
rtl/token_bucket_packet_guard.sv
sim/tbpg_verdict_checker.sv
sim/tb_token_bucket_packet_guard.sv
